// ===== src/spk_pkg.sv =====
// ----------------------------------------------------------------------------
// spk_pkg
// shared types, constants and helper functions of the sparkle-512 sponge
// bit generator: item formats, command queue entry, permutation round logic
// ----------------------------------------------------------------------------
`default_nettype none
package spk_pkg;

  localparam int BRANCHES    = 8;
  localparam int STATE_WORDS = 2 * BRANCHES;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = $clog2(STATE_WORDS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TANK_BITS   = STATE_WORDS * WORD_W;
  localparam int CUR_W       = $clog2(TANK_BITS) + 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [4:0] ROUNDS_RESET = 5'd8;
  localparam logic [4:0] RATE_RESET   = 5'd16;

  localparam logic [WORD_W-1:0] RCON [8] = '{
    32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738,
    32'hBB1185EB, 32'h4F7C7B57, 32'hCFBFA1C8, 32'hC2B3293D
  };

  typedef enum logic [1:0] {
    OP_ABSORB = 2'd0,
    OP_FINISH = 2'd1,
    OP_DRAW   = 2'd2,
    OP_RANGE  = 2'd3
  } spk_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_OVF   = 2'd2
  } spk_status_e;

  typedef enum logic [0:0] {
    CFG_ROUNDS = 1'b0,
    CFG_RATE   = 1'b1
  } spk_cfg_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] data_word;
    logic [6:0]  bit_count;
    logic [63:0] range_lo;
    logic [63:0] range_hi;
  } spk_in_t;

  typedef struct packed {
    logic [63:0] value;
    spk_status_e status;
  } spk_out_t;

  // classified item as it sits in the queue
  typedef struct packed {
    spk_op_e     op;
    logic [31:0] data_word;
    logic [6:0]  nbits;
    logic [63:0] lower;
    logic [63:0] span;
    logic        empty;
  } spk_cmd_t;

  typedef struct packed {
    logic     valid;
    spk_cmd_t cmd;
  } spk_qhead_t;

  typedef struct packed {
    logic              xor_en;
    logic [IDX_W-1:0]  xor_idx;
    logic [WORD_W-1:0] xor_word;
    logic              start;
    logic [IDX_W-1:0]  rd_idx;
  } spk_perm_ctl_t;

  function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] ell(input logic [WORD_W-1:0] x);
    return rotr32(x ^ (x << 16), 16);
  endfunction

  // bit j = parity of x >> j
  function automatic logic [WORD_W-1:0] suffix_par(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x;
    y = y ^ (y >> 1);
    y = y ^ (y >> 2);
    y = y ^ (y >> 4);
    y = y ^ (y >> 8);
    y = y ^ (y >> 16);
    return y;
  endfunction

  // one quarter of an alzette box, returns {x, y}
  function automatic logic [2*WORD_W-1:0] alz_quarter(input logic [WORD_W-1:0] xi,
                                                      input logic [WORD_W-1:0] yi,
                                                      input logic [WORD_W-1:0] rc,
                                                      input logic [1:0] q);
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    x = xi;
    y = yi;
    unique case (q)
      2'd0: begin
        x = x + rotr32(y, 31);
        y = y ^ rotr32(x, 24);
      end
      2'd1: begin
        x = x + rotr32(y, 17);
        y = y ^ rotr32(x, 17);
      end
      2'd2: begin
        x = x + y;
        y = y ^ rotr32(x, 31);
      end
      default: begin
        x = x + rotr32(y, 24);
        y = y ^ rotr32(x, 16);
      end
    endcase
    x = x ^ rc;
    return {x, y};
  endfunction

  function automatic logic [3:0] bitlen8(input logic [7:0] b);
    logic [3:0] l;
    l = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) l = 4'(i + 1);
    end
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== src/spk_front.sv =====
// ----------------------------------------------------------------------------
// spk_front
// accepts items, decodes and range-checks them, and queues them for the back
// ----------------------------------------------------------------------------
`default_nettype none
module spk_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spk_pkg::spk_in_t   in_item_i,
  input  logic               pop_i,
  output spk_pkg::spk_qhead_t head_o
);
  import spk_pkg::*;

  spk_cmd_t          q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  spk_cmd_t          cmd;
  logic              push;
  logic              pop;

  // classify the incoming item
  always_comb begin
    cmd.op        = spk_op_e'(in_item_i.opcode);
    cmd.data_word = in_item_i.data_word;
    cmd.nbits     = (in_item_i.bit_count > 7'd64) ? 7'd64 : in_item_i.bit_count;
    cmd.lower     = in_item_i.range_lo;
    cmd.span      = in_item_i.range_hi - in_item_i.range_lo;
    cmd.empty     = (in_item_i.range_hi <= in_item_i.range_lo);
  end

  assign in_stall_o = (cnt_q == QCNT_W'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = q_mem[rd_ptr_q];

endmodule
`default_nettype wire

// ===== src/spk_perm.sv =====
// ----------------------------------------------------------------------------
// spk_perm
// holds the sixteen state words and runs the sparkle permutation, one
// alzette quarter on all branches per cycle, then the linear layer
// ----------------------------------------------------------------------------
`default_nettype none
module spk_perm (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spk_pkg::spk_perm_ctl_t ctl_i,
  input  logic [4:0]             rounds_i,
  output logic                   busy_o,
  output logic [31:0]            rd_word_o
);
  import spk_pkg::*;

  logic [WORD_W-1:0] s_q [STATE_WORDS];
  logic [WORD_W-1:0] s_d [STATE_WORDS];
  logic              busy_q, busy_d;
  logic [4:0]        step_q, step_d;
  logic [2:0]        phase_q, phase_d;

  always_comb begin
    logic [WORD_W-1:0]   t [STATE_WORDS];
    logic [WORD_W-1:0]   tx;
    logic [WORD_W-1:0]   ty;
    logic [2*WORD_W-1:0] xy;
    s_d     = s_q;
    busy_d  = busy_q;
    step_d  = step_q;
    phase_d = phase_q;
    t       = s_q;
    tx      = '0;
    ty      = '0;
    xy      = '0;
    if (busy_q) begin
      if (phase_q != 3'd4) begin
        if (phase_q == 3'd0) begin
          t[1] = t[1] ^ RCON[step_q[2:0]];
          t[3] = t[3] ^ {27'd0, step_q};
        end
        for (int b = 0; b < BRANCHES; b++) begin
          xy         = alz_quarter(t[2*b], t[2*b+1], RCON[3'(b)], phase_q[1:0]);
          t[2*b]     = xy[2*WORD_W-1:WORD_W];
          t[2*b+1]   = xy[WORD_W-1:0];
        end
        s_d     = t;
        phase_d = 3'(phase_q + 1'b1);
      end else begin
        // linear layer on the old words
        tx = s_q[0];
        ty = s_q[1];
        for (int j = 2; j < BRANCHES; j += 2) begin
          tx = tx ^ s_q[j];
          ty = ty ^ s_q[j+1];
        end
        tx = ell(tx);
        ty = ell(ty);
        for (int j = 2; j < BRANCHES; j += 2) begin
          s_d[j-2]          = s_q[j+BRANCHES] ^ s_q[j] ^ ty;
          s_d[j+BRANCHES]   = s_q[j];
          s_d[j-1]          = s_q[j+BRANCHES+1] ^ s_q[j+1] ^ tx;
          s_d[j+BRANCHES+1] = s_q[j+1];
        end
        s_d[BRANCHES-2] = s_q[BRANCHES] ^ s_q[0] ^ ty;
        s_d[BRANCHES]   = s_q[0];
        s_d[BRANCHES-1] = s_q[BRANCHES+1] ^ s_q[1] ^ tx;
        s_d[BRANCHES+1] = s_q[1];
        phase_d = 3'd0;
        step_d  = 5'(step_q + 1'b1);
        if (5'(step_q + 1'b1) == rounds_i) begin
          busy_d = 1'b0;
        end
      end
    end else begin
      if (ctl_i.xor_en) begin
        s_d[ctl_i.xor_idx] = s_q[ctl_i.xor_idx] ^ ctl_i.xor_word;
      end
      if (ctl_i.start && (rounds_i != 5'd0)) begin
        busy_d  = 1'b1;
        step_d  = 5'd0;
        phase_d = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STATE_WORDS; i++) begin
        s_q[i] <= '0;
      end
      busy_q  <= 1'b0;
      step_q  <= '0;
      phase_q <= '0;
    end else begin
      s_q     <= s_d;
      busy_q  <= busy_d;
      step_q  <= step_d;
      phase_q <= phase_d;
    end
  end

  assign busy_o    = busy_q;
  assign rd_word_o = s_q[ctl_i.rd_idx];

endmodule
`default_nettype wire

// ===== src/spk_back.sv =====
// ----------------------------------------------------------------------------
// spk_back
// carries out queued commands: absorb, finish, bit and range draws; owns
// the bit tank memory, the cursor and the output register
// ----------------------------------------------------------------------------
`default_nettype none
module spk_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spk_pkg::spk_qhead_t    head_i,
  output logic                   pop_o,
  input  logic [4:0]             rate_i,
  output spk_pkg::spk_perm_ctl_t perm_ctl_o,
  input  logic                   perm_busy_i,
  input  logic [31:0]            perm_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output spk_pkg::spk_out_t      out_item_o
);
  import spk_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PERM   = 9'b000000010,
    S_SQZ    = 9'b000000100,
    S_DRAW   = 9'b000001000,
    S_DRAWD  = 9'b000010000,
    S_CHECK  = 9'b000100000,
    S_LEN1   = 9'b001000000,
    S_LEN2   = 9'b010000000,
    S_RESULT = 9'b100000000
  } spk_bstate_e;

  spk_bstate_e       state_q, state_d;
  logic [CNT_W-1:0]  absorbed_q, absorbed_d;
  logic [CUR_W-1:0]  cursor_q, cursor_d;
  logic              fin2_q, fin2_d;
  logic              from_draw_q, from_draw_d;
  logic [IDX_W-1:0]  sidx_q, sidx_d;
  logic [6:0]        nrem_q, nrem_d;
  logic [6:0]        got_q, got_d;
  logic [6:0]        len_q, len_d;
  logic [63:0]       v_q, v_d;
  spk_out_t          res_q, res_d;
  logic [7:0]        byte_nz_q, byte_nz_d;
  logic [3:0]        byte_len_q [8];
  logic [3:0]        byte_len_d [8];
  logic              out_valid_q, out_valid_d;
  spk_out_t          out_q;

  logic [WORD_W-1:0] tank_mem [STATE_WORDS];
  logic [STATE_WORDS-1:0] tank_vld_q, tank_vld_d;
  logic [WORD_W-1:0] rdata_q;
  logic              rvld_q;
  logic              tank_we, tank_re;
  logic [IDX_W-1:0]  tank_wa, tank_ra;
  logic [WORD_W-1:0] tank_wd;

  logic [CNT_W-1:0]  tw;
  logic [CUR_W-1:0]  tsize;
  logic              out_free;
  spk_cmd_t          cmd;

  assign cmd      = head_i.cmd;
  assign tw       = (rate_i == 5'd0) ? CNT_W'(1) :
                    ((rate_i > 5'(STATE_WORDS)) ? CNT_W'(STATE_WORDS) : CNT_W'(rate_i));
  assign tsize    = CUR_W'({tw, 5'd0});
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    logic [WORD_W-1:0] word;
    logic [4:0]        off;
    logic [5:0]        avail;
    logic [5:0]        k;
    logic [WORD_W-1:0] chunk;
    logic [6:0]        len;
    state_d     = state_q;
    absorbed_d  = absorbed_q;
    cursor_d    = cursor_q;
    fin2_d      = fin2_q;
    from_draw_d = from_draw_q;
    sidx_d      = sidx_q;
    nrem_d      = nrem_q;
    got_d       = got_q;
    len_d       = len_q;
    v_d         = v_q;
    res_d       = res_q;
    byte_nz_d   = byte_nz_q;
    byte_len_d  = byte_len_q;
    out_valid_d = out_valid_q && out_stall_i;
    tank_vld_d  = tank_vld_q;
    pop_o       = 1'b0;
    perm_ctl_o  = '0;
    tank_we     = 1'b0;
    tank_re     = 1'b0;
    tank_wa     = sidx_q;
    tank_ra     = cursor_q[CUR_W-2:5];
    tank_wd     = suffix_par(perm_word_i);
    word        = rvld_q ? rdata_q : '0;
    off         = cursor_q[4:0];
    avail       = 6'd32 - {1'b0, off};
    k           = (nrem_q < {1'b0, avail}) ? nrem_q[5:0] : avail;
    chunk       = (word >> off) & ~({WORD_W{1'b1}} << k);
    len         = 7'd0;
    perm_ctl_o.rd_idx = sidx_q;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          res_d.value  = '0;
          res_d.status = ST_OK;
          unique case (cmd.op)
            OP_ABSORB: begin
              if (absorbed_q >= CNT_W'(STATE_WORDS)) begin
                res_d.status = ST_OVF;
              end else begin
                perm_ctl_o.xor_en   = 1'b1;
                perm_ctl_o.xor_idx  = absorbed_q[IDX_W-1:0];
                perm_ctl_o.xor_word = cmd.data_word;
                absorbed_d          = CNT_W'(absorbed_q + 1'b1);
              end
              state_d = S_RESULT;
            end
            OP_FINISH: begin
              // domain bit 0 on the last word, then first permute
              perm_ctl_o.xor_en   = 1'b1;
              perm_ctl_o.xor_idx  = IDX_W'(STATE_WORDS - 1);
              perm_ctl_o.xor_word = 32'd1;
              perm_ctl_o.start    = 1'b1;
              fin2_d      = 1'b0;
              from_draw_d = 1'b0;
              state_d     = S_PERM;
            end
            OP_DRAW: begin
              nrem_d = cmd.nbits;
              got_d  = '0;
              v_d    = '0;
              state_d = (cmd.nbits == 7'd0) ? S_RESULT : S_DRAW;
            end
            default: begin
              if (cmd.empty) begin
                res_d.status = ST_RANGE;
                state_d      = S_RESULT;
              end else begin
                state_d = S_LEN1;
              end
            end
          endcase
        end
      end
      S_PERM: begin
        if (!perm_busy_i) begin
          if (!from_draw_q && !fin2_q) begin
            perm_ctl_o.xor_en   = 1'b1;
            perm_ctl_o.xor_idx  = IDX_W'(STATE_WORDS - 1);
            perm_ctl_o.xor_word = 32'd2;
            perm_ctl_o.start    = 1'b1;
            fin2_d = 1'b1;
          end else begin
            sidx_d  = '0;
            state_d = S_SQZ;
          end
        end
      end
      S_SQZ: begin
        tank_we            = 1'b1;
        tank_vld_d[sidx_q] = 1'b1;
        sidx_d             = IDX_W'(sidx_q + 1'b1);
        if (CNT_W'({1'b0, sidx_q} + 1'b1) == tw) begin
          cursor_d = '0;
          if (from_draw_q) begin
            state_d = S_DRAW;
          end else begin
            absorbed_d   = '0;
            res_d.value  = '0;
            res_d.status = ST_OK;
            state_d      = S_RESULT;
          end
        end
      end
      S_DRAW: begin
        if (cursor_q >= tsize) begin
          // tank used up: permute and refill
          perm_ctl_o.start = 1'b1;
          from_draw_d      = 1'b1;
          state_d          = S_PERM;
        end else begin
          tank_re = 1'b1;
          state_d = S_DRAWD;
        end
      end
      S_DRAWD: begin
        v_d      = v_q | ({32'd0, chunk} << got_q);
        got_d    = 7'(got_q + {1'b0, k});
        nrem_d   = 7'(nrem_q - {1'b0, k});
        cursor_d = CUR_W'(cursor_q + {{(CUR_W-6){1'b0}}, k});
        state_d  = (nrem_q == {1'b0, k}) ? S_CHECK : S_DRAW;
      end
      S_CHECK: begin
        res_d.status = ST_OK;
        if (cmd.op == OP_RANGE) begin
          if (v_q >= cmd.span) begin
            nrem_d  = len_q;
            got_d   = '0;
            v_d     = '0;
            state_d = S_DRAW;
          end else begin
            res_d.value = cmd.lower + v_q;
            state_d     = S_RESULT;
          end
        end else begin
          res_d.value = v_q;
          state_d     = S_RESULT;
        end
      end
      S_LEN1: begin
        for (int i = 0; i < 8; i++) begin
          byte_nz_d[i]  = |cmd.span[8*i +: 8];
          byte_len_d[i] = bitlen8(cmd.span[8*i +: 8]);
        end
        state_d = S_LEN2;
      end
      S_LEN2: begin
        for (int i = 0; i < 8; i++) begin
          if (byte_nz_q[i]) len = 7'(8 * i) + {3'd0, byte_len_q[i]};
        end
        len_d   = len;
        nrem_d  = len;
        got_d   = '0;
        v_d     = '0;
        state_d = S_DRAW;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          pop_o       = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      absorbed_q  <= '0;
      cursor_q    <= '0;
      fin2_q      <= 1'b0;
      from_draw_q <= 1'b0;
      tank_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      absorbed_q  <= absorbed_d;
      cursor_q    <= cursor_d;
      fin2_q      <= fin2_d;
      from_draw_q <= from_draw_d;
      tank_vld_q  <= tank_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sidx_q     <= sidx_d;
    nrem_q     <= nrem_d;
    got_q      <= got_d;
    len_q      <= len_d;
    v_q        <= v_d;
    res_q      <= res_d;
    byte_nz_q  <= byte_nz_d;
    byte_len_q <= byte_len_d;
    if (state_q == S_RESULT && out_free) begin
      out_q <= res_q;
    end
  end

  // tank memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (tank_we) begin
      tank_mem[tank_wa] <= tank_wd;
    end
    if (tank_re) begin
      rdata_q <= tank_mem[tank_ra];
      rvld_q  <= tank_vld_q[tank_ra];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

// ===== src/sparkle512_sponge_bit_generator.sv =====
// ----------------------------------------------------------------------------
// sparkle512_sponge_bit_generator
// random bit generator on a 512-bit sparkle permutation sponge: absorb
// words, finish, then draw bit strings or uniform values from a range
// ----------------------------------------------------------------------------
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+-----------
//  in       | in_valid_i, in_stall_o, in_item_i    | item in
//  out      | out_valid_o, out_stall_i, out_item_o | item out
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | write in
//
//  each permute round runs four alzette quarters on all branches, then
//  the linear layer; a squeeze writes one tank word a cycle
//  finish runs 2 permutes plus a squeeze; a bit draw passes S_DRAW and
//  S_DRAWD for each tank word touched, plus a permute and squeeze whenever
//  the tank runs dry; a range draw first finds the span's bit length in
//  S_LEN1 and S_LEN2, and repeats the draw on each rejection
//  reset clears state words, tank valid bits, cursor and counters at once
//  a two-entry queue lets items be accepted while the back end works or
//  while a finished item waits in the output register
//
`default_nettype none
module sparkle512_sponge_bit_generator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spk_pkg::spk_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spk_pkg::spk_out_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [4:0]        cfg_data_i
);
  import spk_pkg::*;

  // configuration registers
  logic [4:0] rounds_q;
  logic [4:0] rate_q;

  spk_qhead_t    qhead;
  logic          pop;
  spk_perm_ctl_t perm_ctl;
  logic          perm_busy;
  logic [31:0]   perm_word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= ROUNDS_RESET;
      rate_q   <= RATE_RESET;
    end else if (cfg_valid_i) begin
      unique case (spk_cfg_e'(cfg_index_i))
        CFG_ROUNDS: rounds_q <= cfg_data_i;
        CFG_RATE:   rate_q   <= cfg_data_i;
        default:    rounds_q <= rounds_q;
      endcase
    end
  end

  // front: decode, range check, queue
  spk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .pop_i      (pop),
    .head_o     (qhead)
  );

  // permutation unit with the state words
  spk_perm u_perm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (perm_ctl),
    .rounds_i  (rounds_q),
    .busy_o    (perm_busy),
    .rd_word_o (perm_word)
  );

  // back: command sequencer, tank and output register
  spk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (qhead),
    .pop_o       (pop),
    .rate_i      (rate_q),
    .perm_ctl_o  (perm_ctl),
    .perm_busy_i (perm_busy),
    .perm_word_i (perm_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // the back end only retires an item that is in the queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qhead.valid)
    else $error("pop from empty queue");

  // a permute is never started while one is running
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    perm_ctl.start |-> !perm_busy)
    else $error("permute started while busy");

  // retiring an item always presents a result in the next cycle
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("item retired without result");

endmodule
`default_nettype wire

// ===== verif/sparkle512_sponge_bit_generator_test.sv =====
// ----------------------------------------------------------------------------
// sparkle512_sponge_bit_generator_test
// self-checking bench: predicts every result of the sponge generator from its
// own model of the permutation, tank and cursor, under random idling and stall
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module sparkle512_sponge_bit_generator_test;
  import spk_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 400;

  // model of the generator and fifo of predicted results
  class sponge_scoreboard;
    logic [31:0] words [16];
    bit          tank [512];
    int unsigned cursor;
    int unsigned n_absorbed;
    int unsigned rounds;
    int unsigned rate;
    spk_out_t    pending_q [$];
    int          errors;

    function new();
      foreach (words[i]) words[i] = '0;
      foreach (tank[i]) tank[i] = 1'b0;
      cursor = 0;
      n_absorbed = 0;
      rounds = 8;
      rate = 16;
      errors = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function logic [31:0] lin(logic [31:0] x);
      return ror(x ^ (x << 16), 16);
    endfunction

    function int unsigned tank_bits();
      int unsigned w;
      w = rate;
      if (w < 1) w = 1;
      if (w > 16) w = 16;
      return w * 32;
    endfunction

    function void run_rounds();
      logic [31:0] c, tx, ty, x0, y0;
      for (int st = 0; st < rounds; st++) begin
        words[1] ^= RCON[st % 8];
        words[3] ^= 32'(st);
        for (int j = 0; j < 16; j += 2) begin
          c = RCON[(j / 2) % 8];
          words[j] += ror(words[j+1], 31); words[j+1] ^= ror(words[j], 24);
          words[j] ^= c;
          words[j] += ror(words[j+1], 17); words[j+1] ^= ror(words[j], 17);
          words[j] ^= c;
          words[j] += words[j+1];          words[j+1] ^= ror(words[j], 31);
          words[j] ^= c;
          words[j] += ror(words[j+1], 24); words[j+1] ^= ror(words[j], 16);
          words[j] ^= c;
        end
        x0 = words[0]; y0 = words[1]; tx = x0; ty = y0;
        for (int j = 2; j < 8; j += 2) begin
          tx ^= words[j]; ty ^= words[j+1];
        end
        tx = lin(tx); ty = lin(ty);
        for (int j = 2; j < 8; j += 2) begin
          words[j-2] = words[j+8] ^ words[j] ^ ty;
          words[j+8] = words[j];
          words[j-1] = words[j+9] ^ words[j+1] ^ tx;
          words[j+9] = words[j+1];
        end
        words[6] = words[8] ^ x0 ^ ty;
        words[8] = x0;
        words[7] = words[9] ^ y0 ^ tx;
        words[9] = y0;
      end
    endfunction

    function void refill_tank();
      for (int k = 0; k < tank_bits() / 32; k++)
        for (int j = 0; j < 32; j++) tank[k*32+j] = ^(words[k] >> j);
      cursor = 0;
    endfunction

    function logic [63:0] take_bits(int unsigned n);
      logic [63:0] v;
      v = '0;
      if (n > 64) n = 64;
      for (int i = 0; i < n; i++) begin
        if (cursor >= tank_bits()) begin
          run_rounds();
          refill_tank();
        end
        if (tank[cursor % 512]) v[i] = 1'b1;
        cursor++;
      end
      return v;
    endfunction

    function void write_reg(spk_cfg_e idx, logic [4:0] val);
      if (idx == CFG_ROUNDS) rounds = val;
      else rate = val;
    endfunction

    function void note_item(spk_in_t it);
      spk_out_t r;
      logic [63:0] span, t, v;
      int unsigned len;
      r.value = '0;
      r.status = ST_OK;
      case (spk_op_e'(it.opcode))
        OP_ABSORB: begin
          if (n_absorbed >= 16) r.status = ST_OVF;
          else begin
            words[n_absorbed] ^= it.data_word;
            n_absorbed++;
          end
        end
        OP_FINISH: begin
          words[15] ^= 32'd1;
          run_rounds();
          words[15] ^= 32'd2;
          run_rounds();
          refill_tank();
          n_absorbed = 0;
        end
        OP_DRAW: r.value = take_bits(it.bit_count);
        default: begin
          if (it.range_hi <= it.range_lo) r.status = ST_RANGE;
          else begin
            span = it.range_hi - it.range_lo;
            t = span;
            len = 0;
            while (t != 0) begin
              len++;
              t >>= 1;
            end
            do v = take_bits(len); while (v >= span);
            r.value = it.range_lo + v;
          end
        end
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(spk_out_t got);
      spk_out_t exp;
      if (pending_q.size() == 0) begin
        $error("unexpected result value=%h status=%0d", got.value, got.status);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.value !== exp.value) begin
        $error("value: expected %h, actual %h", exp.value, got.value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  spk_in_t    in_item_i;
  logic       out_valid_o;
  logic       out_stall_i;
  spk_out_t   out_item_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [0:0] cfg_index_i;
  logic [4:0] cfg_data_i;

  sponge_scoreboard sb;
  int send_idle_pct;   // chance that the sender leaves a cycle empty
  int recv_stall_pct;  // chance that the receiver stalls a cycle
  int quiet_cycles;

  sparkle512_sponge_bit_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver side: random stall, results checked at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // send one item, with a random idle gap first; valid stays up after the
  // accepting edge until the next item or a drain takes it over
  task automatic send_item(spk_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic write_reg(spk_cfg_e idx, logic [4:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every predicted result, then let the back end settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic spk_in_t make_item(spk_op_e op);
    spk_in_t it;
    logic [63:0] a, b;
    it.opcode      = op;
    it.data_word   = $urandom;
    it.bit_count   = 7'($urandom_range(127));
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    // a mix of narrow, power-of-two wide, empty and random wide ranges
    case ($urandom_range(5))
      0: b = a + 64'($urandom_range(20));
      1: b = a + (64'd1 << $urandom_range(63));
      2: b = a + 64'($urandom_range(1000));
      3: b = a - 64'($urandom_range(3));
      default: ;
    endcase
    it.range_lo = a;
    it.range_hi = b;
    if (op == OP_DRAW && $urandom_range(3) != 0) it.bit_count = 7'($urandom_range(64));
    return it;
  endfunction

  function automatic spk_in_t directed(spk_op_e op, logic [31:0] dw, logic [6:0] n,
                                       logic [63:0] lo, logic [63:0] hi);
    spk_in_t it;
    it.opcode = op; it.data_word = dw; it.bit_count = n;
    it.range_lo = lo; it.range_hi = hi;
    return it;
  endfunction

  task automatic random_phase(int n_items);
    int unsigned r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        // absorb sequence: zero to seventeen absorbs (the last may overflow), then finish
        repeat ($urandom_range(17)) send_item(make_item(OP_ABSORB));
        send_item(make_item(OP_FINISH));
      end else if (r < 70) send_item(make_item(OP_DRAW));
      else if (r < 92) send_item(make_item(OP_RANGE));
      else send_item(make_item(spk_op_e'($urandom_range(3))));
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: draws from the reset tank, field extremes, overflow, ranges
    send_item(directed(OP_DRAW, '0, 7'd0, '0, '0));
    send_item(directed(OP_DRAW, '0, 7'd64, '0, '0));
    for (int i = 0; i < 17; i++) send_item(directed(OP_ABSORB,
        (i % 2) ? 32'hFFFF_FFFF : 32'(i), 7'd127, '1, '0));
    send_item(directed(OP_FINISH, '1, 7'd127, '1, '1));
    send_item(directed(OP_DRAW, '0, 7'd127, '0, '0));
    send_item(directed(OP_DRAW, '0, 7'd1, '0, '0));
    send_item(directed(OP_RANGE, '0, 7'd0, 64'd5, 64'd5));
    send_item(directed(OP_RANGE, '0, 7'd0, '1, '0));
    send_item(directed(OP_RANGE, '0, 7'd0, '0, '1));
    send_item(directed(OP_RANGE, '0, 7'd0, 64'd7, 64'd8));
    send_item(directed(OP_FINISH, '0, '0, '0, '0));
    drain();

    // register settings, extremes included; the rate shrinks under the cursor
    write_reg(CFG_ROUNDS, 5'd0);
    write_reg(CFG_RATE, 5'd0);
    random_phase(20);
    drain();
    write_reg(CFG_ROUNDS, 5'd31);
    write_reg(CFG_RATE, 5'd31);
    send_idle_pct = 47;
    random_phase(35);
    drain();
    write_reg(CFG_ROUNDS, 5'd1);
    write_reg(CFG_RATE, 5'd1);
    send_idle_pct = 0;
    recv_stall_pct = 47;
    random_phase(35);
    drain();
    write_reg(CFG_ROUNDS, 5'd16);
    write_reg(CFG_RATE, 5'd3);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_phase(35);
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_ROUNDS, 5'($urandom_range(31)));
      write_reg(CFG_RATE, 5'($urandom_range(31)));
      send_idle_pct = (p % 2) ? 47 : 0;
      recv_stall_pct = (p / 2) ? 47 : 0;
      random_phase(18);
      drain();
    end
    write_reg(CFG_ROUNDS, 5'd8);
    write_reg(CFG_RATE, 5'd16);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(25);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/spk_pkg.sv
src/spk_front.sv
src/spk_perm.sv
src/spk_back.sv
src/sparkle512_sponge_bit_generator.sv
verif/sparkle512_sponge_bit_generator_test.sv
